### rtl/core/sfjq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the single-server fifo job queue core
// no dependencies; every other file in rtl/core refers to this package

package sfjq_pkg;

  localparam int unsigned QUEUE_DEPTH = 3;
  localparam int unsigned TIME_BITS   = 24;
  localparam int unsigned ID_BITS     = 16;

  // queue index and fill count widths
  localparam int unsigned IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam time_t TIME_MAX = {TIME_BITS{1'b1}};
  localparam cnt_t  CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  typedef enum logic {
    ACT_ARRIVE = 1'b0,
    ACT_END    = 1'b1
  } action_e;

  typedef enum logic {
    OUT_DONE  = 1'b0,
    OUT_ABORT = 1'b1
  } outcome_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    id_t   id;
    time_t arrival;
    time_t length;
    time_t deadline;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    cnt_t count;
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

### rtl/core/sfjq_if.sv
`timescale 1ns / 1ps
// valid/ready channels for job items in and outcome records out
// depends on sfjq_pkg for field types

interface sfjq_job_if;
  logic             valid;
  logic             ready;
  logic             action;
  sfjq_pkg::id_t    job_id;
  sfjq_pkg::time_t  arrival_time;
  sfjq_pkg::time_t  run_length;
  sfjq_pkg::time_t  deadline;

  modport source (output valid, action, job_id, arrival_time, run_length, deadline,
                  input ready);
  modport sink   (input valid, action, job_id, arrival_time, run_length, deadline,
                  output ready);
endinterface

interface sfjq_rec_if;
  logic             valid;
  logic             ready;
  logic             outcome;
  sfjq_pkg::id_t    result_id;
  sfjq_pkg::time_t  event_time;
  sfjq_pkg::time_t  delay;
  logic             last;

  modport source (output valid, outcome, result_id, event_time, delay, last,
                  input ready);
  modport sink   (input valid, outcome, result_id, event_time, delay, last,
                  output ready);
endinterface

### rtl/core/sfjq_fifo.sv
`timescale 1ns / 1ps
// circular waiting queue of jobs with head pointer and fill count
// depends on sfjq_pkg

module sfjq_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfjq_pkg::fifo_ctrl_t ctrl_i,
  input  sfjq_pkg::job_t       wr_job_i,
  output sfjq_pkg::job_t       rd_job_o,
  output sfjq_pkg::fifo_stat_t stat_o
);

  localparam int unsigned SUM_BITS = sfjq_pkg::IDX_BITS + 2;

  sfjq_pkg::job_t mem_q [sfjq_pkg::QUEUE_DEPTH];
  sfjq_pkg::idx_t head_q, head_d;
  sfjq_pkg::cnt_t count_q, count_d;
  logic [SUM_BITS-1:0] tail_sum, head_inc;
  sfjq_pkg::idx_t tail;

  // tail = (head + count) mod depth, sum stays below twice the depth
  always_comb begin
    tail_sum = SUM_BITS'(head_q) + SUM_BITS'(count_q);
    if (tail_sum >= SUM_BITS'(sfjq_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_BITS'(sfjq_pkg::QUEUE_DEPTH);
    end
    tail = tail_sum[sfjq_pkg::IDX_BITS-1:0];
  end

  always_comb begin
    head_inc = SUM_BITS'(head_q) + SUM_BITS'(1);
    if (head_inc >= SUM_BITS'(sfjq_pkg::QUEUE_DEPTH)) begin
      head_inc = '0;
    end
    head_d  = ctrl_i.pop ? head_inc[sfjq_pkg::IDX_BITS-1:0] : head_q;
    count_d = count_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + sfjq_pkg::cnt_t'(1);
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - sfjq_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // entries carry no reset, only the slots the count covers from the head are ever used
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail] <= wr_job_i;
    end
  end

  assign rd_job_o     = mem_q[head_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == sfjq_pkg::CNT_FULL);

endmodule

### rtl/core/sfjq_unit.sv
`timescale 1ns / 1ps
// shared time unit: saturating finish time, fit and expiry tests, clamped delays
// depends on sfjq_pkg

module sfjq_unit (
  input  sfjq_pkg::time_t base_i,
  input  sfjq_pkg::time_t len_i,
  input  sfjq_pkg::time_t dl_i,
  input  sfjq_pkg::time_t arr_i,
  output sfjq_pkg::time_t fin_o,
  output logic            fits_o,
  output logic            expired_o,
  output sfjq_pkg::time_t base_delay_o,
  output sfjq_pkg::time_t dl_delay_o
);

  logic [sfjq_pkg::TIME_BITS:0] sum;

  // exact sum for the fit test, saturated copy for the finish time
  assign sum       = {1'b0, base_i} + {1'b0, len_i};
  assign fits_o    = (sum <= {1'b0, dl_i});
  assign expired_o = (dl_i <= base_i);
  assign fin_o     = sum[sfjq_pkg::TIME_BITS] ? sfjq_pkg::TIME_MAX
                                              : sum[sfjq_pkg::TIME_BITS-1:0];

  assign base_delay_o = (base_i >= arr_i) ? (base_i - arr_i) : '0;
  assign dl_delay_o   = (dl_i >= arr_i) ? (dl_i - arr_i) : '0;

endmodule

### rtl/core/single_server_fifo_job_queue_core.sv
`timescale 1ns / 1ps
// single-server fifo job queue core: each item pops k queued jobs (0..3), one per
// step, and holds the input until its step without a pop; output stalls delay it
// one record at most leaves per cycle, only while the receiver is ready, through a registered
// output stage; the pop loop shares one time unit and the queue's single read port
// async active-low reset clears state, free time, queue pointers and output valid
// depends on sfjq_pkg, sfjq_if, sfjq_fifo and sfjq_unit

module single_server_fifo_job_queue_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfjq_job_if.sink          job_i,
  sfjq_rec_if.source        rec_o
);

  // sequencer
  sfjq_pkg::state_e state_q, state_d;

  // latched item
  sfjq_pkg::action_e act_q;
  sfjq_pkg::id_t     id_q;
  sfjq_pkg::time_t   arr_q;
  sfjq_pkg::time_t   len_q;
  sfjq_pkg::time_t   dl_q;

  // server free time
  sfjq_pkg::time_t free_at_q, free_at_d;

  // output register
  logic               rec_valid_q, rec_valid_d;
  sfjq_pkg::outcome_e rec_outcome_q, rec_outcome_d;
  sfjq_pkg::id_t      rec_id_q, rec_id_d;
  sfjq_pkg::time_t    rec_time_q, rec_time_d;
  sfjq_pkg::time_t    rec_delay_q, rec_delay_d;
  logic               rec_last_q, rec_last_d;

  // queue
  sfjq_pkg::fifo_ctrl_t fifo_ctrl;
  sfjq_pkg::fifo_stat_t fifo_stat;
  sfjq_pkg::job_t       head_job, new_job;

  // time unit operands and results
  sfjq_pkg::time_t u_base, u_len, u_dl, u_arr;
  sfjq_pkg::time_t u_fin, u_base_delay, u_dl_delay;
  logic            u_fits, u_expired;

  logic            step_en;   // output slot free for a new record
  logic            pop_go;    // next step services the queue head
  logic            emit;
  sfjq_pkg::time_t free_next;

  assign job_i.ready = (state_q == sfjq_pkg::ST_IDLE);
  assign step_en     = !rec_valid_q || rec_o.ready;

  // drain while jobs wait, for an end item or a server free by the arrival
  assign pop_go = !fifo_stat.empty &&
                  ((act_q == sfjq_pkg::ACT_END) || (free_at_q <= arr_q));

  assign new_job.id       = id_q;
  assign new_job.arrival  = arr_q;
  assign new_job.length   = len_q;
  assign new_job.deadline = dl_q;

  sfjq_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fifo_ctrl),
    .wr_job_i (new_job),
    .rd_job_o (head_job),
    .stat_o   (fifo_stat)
  );

  // one adder serves both the queued head (at free time) and the arrival itself
  assign u_base = pop_go ? free_at_q          : arr_q;
  assign u_len  = pop_go ? head_job.length    : len_q;
  assign u_dl   = pop_go ? head_job.deadline  : dl_q;
  assign u_arr  = pop_go ? head_job.arrival   : arr_q;

  sfjq_unit u_unit (
    .base_i       (u_base),
    .len_i        (u_len),
    .dl_i         (u_dl),
    .arr_i        (u_arr),
    .fin_o        (u_fin),
    .fits_o       (u_fits),
    .expired_o    (u_expired),
    .base_delay_o (u_base_delay),
    .dl_delay_o   (u_dl_delay)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfjq_pkg::ST_IDLE: begin
        if (job_i.valid) begin
          state_d = sfjq_pkg::ST_RUN;
        end
      end
      sfjq_pkg::ST_RUN: begin
        // the step without a pop settles the item
        if (step_en && !pop_go) begin
          state_d = sfjq_pkg::ST_IDLE;
        end
      end
      default: state_d = sfjq_pkg::ST_IDLE;
    endcase
  end

  // step outputs
  always_comb begin
    fifo_ctrl     = '0;
    free_at_d     = free_at_q;
    free_next     = free_at_q;
    emit          = 1'b0;
    rec_outcome_d = rec_outcome_q;
    rec_id_d      = rec_id_q;
    rec_time_d    = rec_time_q;
    rec_delay_d   = rec_delay_q;
    rec_last_d    = rec_last_q;

    case (state_q)
      sfjq_pkg::ST_RUN: begin
        if (step_en) begin
          if (pop_go) begin
            fifo_ctrl.pop = 1'b1;
            emit          = 1'b1;
            rec_id_d      = head_job.id;
            if (u_expired) begin
              // deadline already gone: abort at free time, server stays free
              rec_outcome_d = sfjq_pkg::OUT_ABORT;
              rec_time_d    = free_at_q;
              rec_delay_d   = u_base_delay;
            end else if (u_fits) begin
              rec_outcome_d = sfjq_pkg::OUT_DONE;
              rec_time_d    = u_fin;
              rec_delay_d   = u_base_delay;
              free_next     = u_fin;
            end else begin
              // runs up to its deadline and is cut off there
              rec_outcome_d = sfjq_pkg::OUT_ABORT;
              rec_time_d    = head_job.deadline;
              rec_delay_d   = u_dl_delay;
              free_next     = head_job.deadline;
            end
            free_at_d = free_next;
            // end of stream: last pop empties the queue
            // arrival: once the server is busy past it, the arrival only queues
            if (act_q == sfjq_pkg::ACT_END) begin
              rec_last_d = (fifo_stat.count == sfjq_pkg::cnt_t'(1));
            end else begin
              rec_last_d = (free_next > arr_q);
            end
          end else if (act_q == sfjq_pkg::ACT_ARRIVE) begin
            if (free_at_q <= arr_q) begin
              // idle server: start at once, no deadline check
              emit          = 1'b1;
              rec_outcome_d = sfjq_pkg::OUT_DONE;
              rec_id_d      = id_q;
              rec_time_d    = u_fin;
              rec_delay_d   = '0;
              rec_last_d    = 1'b1;
              free_at_d     = u_fin;
            end else if (!fifo_stat.full) begin
              fifo_ctrl.push = 1'b1;
            end else begin
              // busy and queue full: reject on arrival
              emit          = 1'b1;
              rec_outcome_d = sfjq_pkg::OUT_ABORT;
              rec_id_d      = id_q;
              rec_time_d    = arr_q;
              rec_delay_d   = '0;
              rec_last_d    = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (emit) begin
      rec_valid_d = 1'b1;
    end else if (rec_o.ready) begin
      rec_valid_d = 1'b0;
    end else begin
      rec_valid_d = rec_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfjq_pkg::ST_IDLE;
      free_at_q   <= '0;
      rec_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_at_q   <= free_at_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  // item capture and record payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (job_i.valid && job_i.ready) begin
      act_q <= sfjq_pkg::action_e'(job_i.action);
      id_q  <= job_i.job_id;
      arr_q <= job_i.arrival_time;
      len_q <= job_i.run_length;
      dl_q  <= job_i.deadline;
    end
    rec_outcome_q <= rec_outcome_d;
    rec_id_q      <= rec_id_d;
    rec_time_q    <= rec_time_d;
    rec_delay_q   <= rec_delay_d;
    rec_last_q    <= rec_last_d;
  end

  assign rec_o.valid      = rec_valid_q;
  assign rec_o.outcome    = rec_outcome_q;
  assign rec_o.result_id  = rec_id_q;
  assign rec_o.event_time = rec_time_q;
  assign rec_o.delay      = rec_delay_q;
  assign rec_o.last       = rec_last_q;

endmodule

### tb/sv/tb_single_server_fifo_job_queue_core.sv
`timescale 1ns / 1ps
// self-checking bench for the single-server fifo job queue core: a scoreboard
// class predicts done/abort records per job item, plain tasks drive the job channel
// depends on sfjq_pkg, sfjq_if and single_server_fifo_job_queue_core

module tb_single_server_fifo_job_queue_core;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned HOLD_CYCLES    = 200;   // long receiver back-pressure stretch
  localparam int unsigned DRAIN_CYCLES   = 20;    // settle time after the last record
  localparam int unsigned RANDOM_ITEMS   = 150;

  typedef struct packed {
    sfjq_pkg::action_e action;
    sfjq_pkg::id_t     id;
    sfjq_pkg::time_t   arrival;
    sfjq_pkg::time_t   length;
    sfjq_pkg::time_t   deadline;
  } job_item_t;

  typedef struct packed {
    sfjq_pkg::outcome_e outcome;
    sfjq_pkg::id_t      id;
    sfjq_pkg::time_t    event_time;
    sfjq_pkg::time_t    delay;
    logic               last;
  } outcome_rec_t;

  // scoreboard: private copy of the server state and the records still owed
  class sfjq_outcome_board;
    sfjq_pkg::time_t free_time;
    job_item_t       waiting[$];
    outcome_rec_t    due[$];
    outcome_rec_t    held;
    bit              have_held;
    int unsigned     mismatches;

    function new();
      free_time  = '0;
      have_held  = 1'b0;
      mismatches = 0;
    endfunction

    static function sfjq_pkg::time_t clip(logic [sfjq_pkg::TIME_BITS:0] v);
      return (v > {1'b0, sfjq_pkg::TIME_MAX}) ? sfjq_pkg::TIME_MAX
                                              : v[sfjq_pkg::TIME_BITS-1:0];
    endfunction

    static function sfjq_pkg::time_t span(sfjq_pkg::time_t later,
                                          sfjq_pkg::time_t earlier);
      return (later >= earlier) ? sfjq_pkg::time_t'(later - earlier) : '0;
    endfunction

    // one record is held back so the final one of an item can get its last flag
    function void emit(sfjq_pkg::outcome_e o, sfjq_pkg::id_t id,
                       sfjq_pkg::time_t at, sfjq_pkg::time_t dly);
      if (have_held) due.push_back(held);
      held.outcome    = o;
      held.id         = id;
      held.event_time = at;
      held.delay      = dly;
      held.last       = 1'b0;
      have_held       = 1'b1;
    endfunction

    // pop waiting jobs at the current free time until one starts or none is left
    function void serve();
      job_item_t                    head;
      sfjq_pkg::time_t              start;
      logic [sfjq_pkg::TIME_BITS:0] fin;
      start = free_time;
      while (waiting.size() > 0) begin
        head = waiting.pop_front();
        if (head.deadline <= start) begin
          // deadline already gone, abort now and try the next one
          emit(sfjq_pkg::OUT_ABORT, head.id, start, span(start, head.arrival));
        end else begin
          // exact sum, so an overflowing finish can not sneak under the deadline
          fin = {1'b0, start} + {1'b0, head.length};
          if (fin <= {1'b0, head.deadline}) begin
            emit(sfjq_pkg::OUT_DONE, head.id, clip(fin), span(start, head.arrival));
            free_time = clip(fin);
          end else begin
            emit(sfjq_pkg::OUT_ABORT, head.id, head.deadline,
                 span(head.deadline, head.arrival));
            free_time = head.deadline;
          end
          return;
        end
      end
    endfunction

    function void note_job(job_item_t j);
      logic [sfjq_pkg::TIME_BITS:0] fin;
      if (j.action == sfjq_pkg::ACT_END) begin
        while (waiting.size() > 0) serve();
      end else begin
        while (waiting.size() > 0 && free_time <= j.arrival) serve();
        if (free_time <= j.arrival) begin
          // idle server: start at once, no deadline check
          fin       = {1'b0, j.arrival} + {1'b0, j.length};
          free_time = clip(fin);
          emit(sfjq_pkg::OUT_DONE, j.id, free_time, '0);
        end else if (waiting.size() < sfjq_pkg::QUEUE_DEPTH) begin
          waiting.push_back(j);
        end else begin
          emit(sfjq_pkg::OUT_ABORT, j.id, j.arrival, '0);
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        due.push_back(held);
        have_held = 1'b0;
      end
    endfunction

    function void check_record(outcome_rec_t got);
      outcome_rec_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected record: outcome %0d id %h time %h delay %h last %b",
                   got.outcome, got.id, got.event_time, got.delay, got.last);
        return;
      end
      want = due.pop_front();
      if (got.outcome !== want.outcome || got.id !== want.id ||
          got.event_time !== want.event_time || got.delay !== want.delay ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("record mismatch: expected outcome %0d id %h time %h delay %h last %b",
                   want.outcome, want.id, want.event_time, want.delay, want.last);
          $display("                 actual   outcome %0d id %h time %h delay %h last %b",
                   got.outcome, got.id, got.event_time, got.delay, got.last);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sfjq_job_if job_bus ();
  sfjq_rec_if rec_bus ();

  single_server_fifo_job_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_bus),
    .rec_o  (rec_bus)
  );

  sfjq_outcome_board board = new();

  bit          no_idle;      // both sides run back to back while set
  bit          rx_hold;      // receiver is in its long back-pressure stretch
  int unsigned quiet_cycles;
  int unsigned stim_time;    // running arrival time of the stimulus

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // per-item wait for either side; zero while bursting or while the receiver holds
  function automatic int unsigned pick_gap();
    if (no_idle || rx_hold) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // offer one item from a falling edge on and wait for the handshake
  task automatic send_job(job_item_t j);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      job_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    job_bus.valid        <= 1'b1;
    job_bus.action       <= j.action;
    job_bus.job_id       <= j.id;
    job_bus.arrival_time <= j.arrival;
    job_bus.run_length   <= j.length;
    job_bus.deadline     <= j.deadline;
    @(posedge clk_i);
    while (!job_bus.ready) @(posedge clk_i);
    board.note_job(j);
  endtask

  task automatic offer_arrival(sfjq_pkg::id_t id, int unsigned a, int unsigned len,
                               int unsigned dl);
    job_item_t j;
    j.action   = sfjq_pkg::ACT_ARRIVE;
    j.id       = id;
    j.arrival  = sfjq_pkg::time_t'(a);
    j.length   = sfjq_pkg::time_t'(len);
    j.deadline = sfjq_pkg::time_t'(dl);
    send_job(j);
  endtask

  // end of stream; the payload fields are ignored, so fill them with noise
  task automatic offer_end();
    job_item_t j;
    j.action   = sfjq_pkg::ACT_END;
    j.id       = sfjq_pkg::id_t'($urandom);
    j.arrival  = sfjq_pkg::time_t'($urandom);
    j.length   = sfjq_pkg::time_t'($urandom);
    j.deadline = sfjq_pkg::time_t'($urandom);
    send_job(j);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sel;
    int unsigned a;
    int unsigned len;
    int unsigned dl;
    for (int unsigned i = 0; i < count; i++) begin
      // switch between idling and back-to-back stretches now and then
      if (i % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        offer_end();
      end else begin
        if (sel < 12 && stim_time > 50) begin
          // out-of-order arrival, time base left where it is
          a = stim_time - $urandom_range(1, 50);
        end else begin
          stim_time = stim_time + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
          a = stim_time;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 400) : $urandom_range(1, 30);
        case ($urandom_range(0, 4))
          0: dl = a + len + $urandom_range(0, 60);                 // loose
          1: dl = a + $urandom_range(0, len);                      // tight, at most an exact fit
          2: dl = (a > 40) ? a - $urandom_range(0, 40) : 0;        // already past
          3: dl = a + len;                                         // exact fit
          default: dl = ($urandom_range(0, 7) == 0) ? 32'(sfjq_pkg::TIME_MAX)
                                                    : a + $urandom_range(0, 3 * len);
        endcase
        offer_arrival(sfjq_pkg::id_t'($urandom), a, len, dl);
      end
    end
  endtask

  // receiver: random stalls per record, one long hold to back the block up
  initial begin
    int unsigned  stall_left;
    int unsigned  records_seen;
    bit           pressed;
    outcome_rec_t got;
    rec_bus.ready = 1'b0;
    stall_left    = 0;
    records_seen  = 0;
    pressed       = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rec_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rec_bus.ready <= 1'b1;
        rx_hold = 1'b0;
      end
      @(posedge clk_i);
      if (rec_bus.valid && rec_bus.ready) begin
        got.outcome    = sfjq_pkg::outcome_e'(rec_bus.outcome);
        got.id         = rec_bus.result_id;
        got.event_time = rec_bus.event_time;
        got.delay      = rec_bus.delay;
        got.last       = rec_bus.last;
        board.check_record(got);
        records_seen++;
        if (!pressed && records_seen == 30) begin
          pressed    = 1'b1;
          rx_hold    = 1'b1;
          stall_left = HOLD_CYCLES;
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  // watchdog: too long without any handshake on either channel
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((job_bus.valid && job_bus.ready) || (rec_bus.valid && rec_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    no_idle              = 1'b0;
    rx_hold              = 1'b0;
    stim_time            = 0;
    job_bus.valid        = 1'b0;
    job_bus.action       = sfjq_pkg::ACT_ARRIVE;
    job_bus.job_id       = '0;
    job_bus.arrival_time = '0;
    job_bus.run_length   = '0;
    job_bus.deadline     = '0;
    rst_ni               = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle start runs despite an impossible deadline
    offer_arrival(16'h0000, 1, 10, 5);
    // fill the queue, then one more is turned away at once
    offer_arrival(16'hFFFF, 2, 3, 20);
    offer_arrival(16'h0002, 3, 5, 6);
    offer_arrival(16'h0003, 4, 30, 40);
    offer_arrival(16'h0004, 5, 8, 90);
    // late arrival drains all three: done, deadline passed, cut off at deadline
    offer_arrival(16'h0005, 50, 2, 100);
    // end with nothing waiting gives no record
    offer_end();
    // arrival exactly at the free time starts immediately
    offer_arrival(16'h0006, 52, 4, 0);
    // finish exactly on the deadline, then a zero deadline
    offer_arrival(16'h0007, 53, 3, 59);
    offer_arrival(16'h0008, 54, 1, 0);
    offer_end();
    // arrivals going backwards in time, one with deadline before arrival
    offer_arrival(16'h0009, 30, 5, 62);
    offer_arrival(16'h000A, 20, 1, 10);
    offer_end();

    // random traffic from a far jump in the time base; state carries over
    stim_time = $urandom_range(24'h100000, 24'hBFFFFF);
    run_random(RANDOM_ITEMS);
    offer_end();
    no_idle = 1'b0;

    // saturation at the top of the time range, last since free time never falls
    offer_arrival(16'h1234, 24'hFFFFE0, 24'h10, 24'hFFFFFF);
    // exact finish overflows past the deadline, so it must be cut off there
    offer_arrival(16'hA5A5, 24'hFFFFE1, 24'h20, 24'hFFFFFF);
    offer_end();
    offer_arrival(16'h5A5A, 24'hFFFFFF, 24'hFFFFFF, 0);
    offer_arrival(16'h8001, 24'hFFFFFE, 7, 24'hFFFFFF);
    offer_arrival(16'h7FFE, 24'hFFFFFF, 1, 24'hFFFFFF);
    offer_end();

    @(negedge clk_i);
    job_bus.valid <= 1'b0;

    // wait for every owed record, then a few more cycles for strays
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.due.size() != 0)
      $display("%0d expected records never arrived", board.due.size());
    if (board.mismatches == 0 && board.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d record mismatches", board.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
